FILE: design/tpq_pkg.sv
// Shared types, codes and defaults for the class queue bank.
package tpq_pkg;

    // Default sizes
    localparam int DEF_NUM_CLASSES = 32;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_TAG_BITS    = 16;

    // Fixed field widths
    localparam int CLASS_W   = 5;
    localparam int CAP_W     = 4;
    localparam int OUTCOME_W = 2;
    localparam int LEN_OUT_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    // Item operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_ADDED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FULL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_TAKEN = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FETCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // latch item, read class pointer/length
        logic add_commit;   // write entry, update pointer/length, report added
        logic add_reject;   // report full
        logic take_commit;  // read head entry, update pointer/length
        logic take_empty;   // report empty
        logic take_done;    // report taken entry
    } tpq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_take;
        logic full;
        logic empty;
    } tpq_sts_t;

endpackage

FILE: design/tpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tpq_ctrl.sv
// Sequencer for the class queue bank: one item at a time.
module tpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tpq_pkg::tpq_sts_t sts,
    output tpq_pkg::tpq_cmd_t cmd,
    output logic              busy
);
    import tpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!sts.op_take)
                begin
                    cmd.add_commit = !sts.full;
                    cmd.add_reject = sts.full;
                    state_next     = ST_IDLE;
                end
                else if (sts.empty)
                begin
                    cmd.take_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.take_commit = 1'b1;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.take_done = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: design/tpq_datapath.sv
// Datapath: limit register, per-class pointer/length RAM, entry RAM, result registers.
module tpq_datapath #(
    parameter int NUM_CLASSES = tpq_pkg::DEF_NUM_CLASSES,
    parameter int QUEUE_DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = tpq_pkg::DEF_TAG_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tpq_pkg::tpq_cmd_t               cmd,
    output tpq_pkg::tpq_sts_t               sts,
    input  logic                            op,
    input  logic [tpq_pkg::CLASS_W-1:0]     class_index,
    input  logic [TAG_BITS-1:0]             entry_tag,
    input  logic                            urgent,
    input  logic                            cfg_wr_en,
    input  logic [tpq_pkg::CAP_W-1:0]       cfg_wr_data,
    output logic                            done,
    output logic [tpq_pkg::OUTCOME_W-1:0]   outcome,
    output logic [TAG_BITS-1:0]             taken_tag,
    output logic                            taken_urgent,
    output logic [tpq_pkg::LEN_OUT_W-1:0]   length_after
);
    import tpq_pkg::*;

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int META_W = PTR_W + LEN_W;
    localparam int SLOTS  = NUM_CLASSES * QUEUE_DEPTH;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SUM_W  = PTR_W + 2;
    localparam int CMP_W  = (LEN_W > CAP_W) ? LEN_W : CAP_W;
    localparam int MAP_N  = 2 ** CLASS_W;

    // Class index reduced modulo the class count, worked out at elaboration
    logic [CLS_W-1:0] cls_map [MAP_N];

    for (genvar i = 0; i < MAP_N; i++)
    begin : g_cls_map
        assign cls_map[i] = CLS_W'(i % NUM_CLASSES);
    end

    logic [CAP_W-1:0]    cap_limit_reg;
    logic                op_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                urg_reg;
    logic [NUM_CLASSES-1:0] valid_reg;

    logic                done_reg;
    logic                done_next;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [OUTCOME_W-1:0] outcome_next;
    logic [TAG_BITS-1:0] taken_tag_reg;
    logic [TAG_BITS-1:0] taken_tag_next;
    logic                taken_urg_reg;
    logic                taken_urg_next;
    logic [LEN_W-1:0]    len_after_reg;
    logic [LEN_W-1:0]    len_after_next;

    logic [META_W-1:0]   meta_rdata;
    logic [META_W-1:0]   meta_wdata;
    logic                meta_we;
    logic [TAG_BITS:0]   entry_rdata;

    logic [PTR_W-1:0]    cur_head;
    logic [LEN_W-1:0]    cur_len;
    logic [PTR_W-1:0]    head_dec;
    logic [PTR_W-1:0]    head_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [PTR_W-1:0]    tail_pos;
    logic [PTR_W-1:0]    new_head;
    logic [LEN_W-1:0]    new_len;
    logic [PTR_W-1:0]    slot_pos;
    logic [SLOT_W-1:0]   slot_addr;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    limit;

    // Capacity limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_limit_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_limit_reg <= cfg_wr_data;
        end
    end

    // Item holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            cls_reg <= cls_map[class_index];
            tag_reg <= entry_tag;
            urg_reg <= urgent;
        end
    end

    // Per-class pointer/length: head in upper bits, length in lower bits
    tpq_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_CLASSES)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (cls_reg),
        .wdata (meta_wdata),
        .re    (cmd.load),
        .raddr (cls_map[class_index]),
        .rdata (meta_rdata)
    );

    // A class never written reads as empty with head zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (meta_we)
        begin
            valid_reg[cls_reg] <= 1'b1;
        end
    end

    assign cur_head = valid_reg[cls_reg] ? meta_rdata[META_W-1:LEN_W] : '0;
    assign cur_len  = valid_reg[cls_reg] ? meta_rdata[LEN_W-1:0] : '0;

    // Limit saturates at the ring size
    assign cap_ext = CMP_W'(cap_limit_reg);
    assign limit   = (cap_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : cap_ext;

    assign sts.op_take = op_reg;
    assign sts.full    = (CMP_W'(cur_len) >= limit);
    assign sts.empty   = (cur_len == '0);

    // Ring pointer arithmetic
    assign head_dec = (cur_head == '0) ? PTR_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
    assign head_inc = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_len);
    assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                      : PTR_W'(tail_sum);

    // Urgent add goes in front of the head, regular add at the tail
    always_comb
    begin
        if (cmd.add_commit)
        begin
            new_head = urg_reg ? head_dec : cur_head;
            new_len  = cur_len + 1'b1;
            slot_pos = urg_reg ? head_dec : tail_pos;
        end
        else
        begin
            new_head = head_inc;
            new_len  = cur_len - 1'b1;
            slot_pos = cur_head;
        end
    end

    assign slot_addr  = SLOT_W'(cls_reg) * SLOT_W'(QUEUE_DEPTH) + SLOT_W'(slot_pos);
    assign meta_we    = cmd.add_commit | cmd.take_commit;
    assign meta_wdata = {new_head, new_len};

    // Entry store: tag with urgency flag in the low bit
    tpq_ram #(
        .WIDTH (TAG_BITS + 1),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.add_commit),
        .waddr (slot_addr),
        .wdata ({tag_reg, urg_reg}),
        .re    (cmd.take_commit),
        .raddr (slot_addr),
        .rdata (entry_rdata)
    );

    // Result next values
    always_comb
    begin
        done_next      = cmd.add_commit | cmd.add_reject | cmd.take_empty | cmd.take_done;
        outcome_next   = outcome_reg;
        taken_tag_next = '0;
        taken_urg_next = 1'b0;
        len_after_next = len_after_reg;
        if (cmd.add_commit)
        begin
            outcome_next   = OUT_ADDED;
            len_after_next = new_len;
        end
        if (cmd.add_reject)
        begin
            outcome_next   = OUT_FULL;
            len_after_next = cur_len;
        end
        if (cmd.take_empty)
        begin
            outcome_next   = OUT_EMPTY;
            len_after_next = '0;
        end
        if (cmd.take_commit)
        begin
            outcome_next   = OUT_TAKEN;
            len_after_next = new_len;
        end
        if (cmd.take_done)
        begin
            taken_tag_next = entry_rdata[TAG_BITS:1];
            taken_urg_next = entry_rdata[0];
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        outcome_reg   <= outcome_next;
        taken_tag_reg <= taken_tag_next;
        taken_urg_reg <= taken_urg_next;
        len_after_reg <= len_after_next;
    end

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign taken_tag    = taken_tag_reg;
    assign taken_urgent = taken_urg_reg;
    assign length_after = LEN_OUT_W'(len_after_reg);

endmodule

FILE: design/two_priority_queue_bank.sv
// Top level of the class queue bank: controller plus datapath.
//
// A bank of bounded queues, one per class. An item is taken when start is
// high and busy is low: op selects add or take, class_index picks the queue,
// entry_tag and urgent describe an added entry (urgent entries go to the
// head). Each item gives one result, shown for one cycle with done high:
// outcome, taken_tag/taken_urgent (zero unless an entry was taken) and
// length_after. The receiver cannot stall; a result is gone after its cycle.
// Timing: an add, a rejected add or a take from an empty queue shows its
// result after the registered read of the per-class pointer/length RAM; a
// successful take also waits on the registered read of the entry RAM. busy
// drops with the result, so a new item is taken only once the last one is done.
// capacity_limit is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, the block itself does not enforce it.
// Reset: all queues empty, limit 5, no clearing pass; entry RAM contents are
// undefined and only read after being written.
module two_priority_queue_bank #(
    parameter int NUM_CLASSES = tpq_pkg::DEF_NUM_CLASSES,
    parameter int QUEUE_DEPTH = tpq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = tpq_pkg::DEF_TAG_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            op,
    input  logic [tpq_pkg::CLASS_W-1:0]     class_index,
    input  logic [TAG_BITS-1:0]             entry_tag,
    input  logic                            urgent,
    input  logic                            cfg_wr_en,
    input  logic [tpq_pkg::CAP_W-1:0]       cfg_wr_data,
    output logic                            done,
    output logic [tpq_pkg::OUTCOME_W-1:0]   outcome,
    output logic [TAG_BITS-1:0]             taken_tag,
    output logic                            taken_urgent,
    output logic [tpq_pkg::LEN_OUT_W-1:0]   length_after
);
    import tpq_pkg::*;

    tpq_cmd_t cmd;
    tpq_sts_t sts;

    tpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tpq_datapath #(
        .NUM_CLASSES (NUM_CLASSES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (op),
        .class_index  (class_index),
        .entry_tag    (entry_tag),
        .urgent       (urgent),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .outcome      (outcome),
        .taken_tag    (taken_tag),
        .taken_urgent (taken_urgent),
        .length_after (length_after)
    );

endmodule

FILE: design/tpq_checker.sv
// Port-level checks for the class queue bank, bound to the top level.
module tpq_checker #(
    parameter int TAG_BITS = tpq_pkg::DEF_TAG_BITS
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [tpq_pkg::OUTCOME_W-1:0]   outcome,
    input logic [TAG_BITS-1:0]             taken_tag,
    input logic                            taken_urgent,
    input logic [tpq_pkg::LEN_OUT_W-1:0]   length_after
);
    import tpq_pkg::*;

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result beat comes only once the item is finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // Every item passes through the lookup state, so beats never abut
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats in consecutive cycles");

    // Only a taken entry carries tag and urgency
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome != OUT_TAKEN) |-> (taken_tag == '0 && !taken_urgent))
        else $error("tag or urgency set on a result without a taken entry");

    // An empty report leaves the queue empty
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome == OUT_EMPTY) |-> (length_after == '0))
        else $error("empty outcome with nonzero length");

endmodule

bind two_priority_queue_bank tpq_checker #(.TAG_BITS(TAG_BITS)) u_tpq_checker (.*);

FILE: tb/tb_two_priority_queue_bank.sv
// Self-checking testbench for the class queue bank: directed table, random phases, predictor.
module tb_two_priority_queue_bank;
    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int TAG_W      = DEF_TAG_BITS;
    localparam int DEPTH      = DEF_QUEUE_DEPTH;
    localparam int CLASSES    = DEF_NUM_CLASSES;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_BEATS = 235;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic               op;
        logic [CLASS_W-1:0] cls;
        logic [TAG_W-1:0]   tag;
        logic               urg;
    } queue_op_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [TAG_W-1:0]     tag;
        logic                 urg;
        logic [LEN_OUT_W-1:0] len;
    } queue_res_t;

    typedef struct packed {
        queue_op_t  op_in;
        logic       typed;   // expected result given in the row
        queue_res_t res;
    } dir_row_t;

    // DUT signals, the inputs all known from time zero
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 op = OP_ADD;
    logic [CLASS_W-1:0]   class_index = '0;
    logic [TAG_W-1:0]     entry_tag = '0;
    logic                 urgent = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 done;
    logic [OUTCOME_W-1:0] outcome;
    logic [TAG_W-1:0]     taken_tag;
    logic                 taken_urgent;
    logic [LEN_OUT_W-1:0] length_after;

    // Predictor state
    logic [TAG_W-1:0]     tag_mem [CLASSES][DEPTH];
    logic                 urg_mem [CLASSES][DEPTH];
    logic [LEN_OUT_W-1:0] q_len [CLASSES];
    logic [2:0]           q_head [CLASSES];
    logic [CAP_W-1:0]     cap_limit;

    queue_res_t pending_results[$];
    dir_row_t   dir_rows[$];
    int         mismatches = 0;
    int         cycles = 0;

    int phase_cap[NUM_PHASES]     = '{8, 2, 15, 0, 1, 9, 3, 5};
    int phase_add_pct[NUM_PHASES] = '{72, 45, 65, 50, 55, 60, 40, 50};

    two_priority_queue_bank uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .class_index  (class_index),
        .entry_tag    (entry_tag),
        .urgent       (urgent),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .outcome      (outcome),
        .taken_tag    (taken_tag),
        .taken_urgent (taken_urgent),
        .length_after (length_after)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one beat to the predictor state and return its result
    function automatic queue_res_t predict_queue_op(queue_op_t it);
        queue_res_t           r;
        logic [LEN_OUT_W-1:0] n;
        logic [LEN_OUT_W-1:0] lim;
        logic [2:0]           h;
        logic [2:0]           slot;
        r = '0;
        n = q_len[it.cls];
        h = q_head[it.cls];
        lim = (cap_limit > LEN_OUT_W'(DEPTH)) ? LEN_OUT_W'(DEPTH) : cap_limit;
        if (it.op == OP_ADD)
        begin
            if (n >= lim)
                r.outcome = OUT_FULL;
            else
            begin
                // urgent goes in front of the head, regular after the tail
                if (it.urg)
                begin
                    h = h - 3'd1;
                    slot = h;
                end
                else
                    slot = h + n[2:0];
                tag_mem[it.cls][slot] = it.tag;
                urg_mem[it.cls][slot] = it.urg;
                n = n + 1'b1;
                r.outcome = OUT_ADDED;
            end
        end
        else if (n == 0)
            r.outcome = OUT_EMPTY;
        else
        begin
            r.tag = tag_mem[it.cls][h];
            r.urg = urg_mem[it.cls][h];
            h = h + 3'd1;
            n = n - 1'b1;
            r.outcome = OUT_TAKEN;
        end
        q_len[it.cls] = n;
        q_head[it.cls] = h;
        r.len = n;
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic o, int c, int t, logic u, logic typed,
                                        logic [OUTCOME_W-1:0] oc, int tt, logic tu, int ln);
        dir_row_t row;
        row.op_in = '{op: o, cls: CLASS_W'(c), tag: TAG_W'(t), urg: u};
        row.typed = typed;
        row.res = '{outcome: oc, tag: TAG_W'(tt), urg: tu, len: LEN_OUT_W'(ln)};
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] want_v,
                                   input logic [TAG_W-1:0] got_v);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    // Present one beat, hold it until accepted, then record what it should give
    task automatic send_beat(input queue_op_t it, input logic typed, input queue_res_t typed_res);
        queue_res_t pred;
        start       <= 1'b1;
        op          <= it.op;
        class_index <= it.cls;
        entry_tag   <= it.tag;
        urgent      <= it.urg;
        do
            @(posedge clk);
        while (busy);
        pred = predict_queue_op(it);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic idle_gap(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every result drain, then write the limit
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_limit = value;
    endtask

    // Result checker: one beat per done cycle, oldest expectation first
    always @(posedge clk)
    begin : check_results
        queue_res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, outcome", '0, TAG_W'(outcome));
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome)
                    report_mismatch("outcome", TAG_W'(want.outcome), TAG_W'(outcome));
                if (taken_tag !== want.tag)
                    report_mismatch("taken_tag", want.tag, taken_tag);
                if (taken_urgent !== want.urg)
                    report_mismatch("taken_urgent", TAG_W'(want.urg), TAG_W'(taken_urgent));
                if (length_after !== want.len)
                    report_mismatch("length_after", TAG_W'(want.len), TAG_W'(length_after));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        queue_op_t          it;
        logic [CLASS_W-1:0] hot_base;
        bit                 no_gaps;

        foreach (q_len[c])
        begin
            q_len[c] = '0;
            q_head[c] = '0;
        end
        cap_limit = CAP_RESET;

        // Directed rows at the reset limit of 5
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'hFFFF, 1, 1, OUT_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 31, 0, 0, 1, OUT_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD, 0, 'h0000, 0, 1, OUT_ADDED, 0, 0, 1));
        dir_rows.push_back(mk_row(OP_ADD, 0, 'hFFFF, 0, 1, OUT_ADDED, 0, 0, 2));
        dir_rows.push_back(mk_row(OP_ADD, 0, 'h1234, 1, 1, OUT_ADDED, 0, 0, 3));
        dir_rows.push_back(mk_row(OP_ADD, 0, 'hABCD, 1, 0, OUT_ADDED, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD, 0, 'h5555, 0, 0, OUT_ADDED, 0, 0, 0));
        // queue at the limit: rejected
        dir_rows.push_back(mk_row(OP_ADD, 0, 'hAAAA, 1, 1, OUT_FULL, 0, 0, 5));
        // urgent entries come out newest first, then the regular ones in order
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'hFFFF, 1, 0, OUT_TAKEN, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'h0000, 0, 0, OUT_TAKEN, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'h5A5A, 1, 0, OUT_TAKEN, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'h0000, 0, 0, OUT_TAKEN, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'h0000, 0, 0, OUT_TAKEN, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_TAKE, 0, 'hFFFF, 1, 1, OUT_EMPTY, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_ADD, 31, 'h8001, 1, 1, OUT_ADDED, 0, 0, 1));
        dir_rows.push_back(mk_row(OP_ADD, 31, 'h7FFE, 0, 1, OUT_ADDED, 0, 0, 2));
        dir_rows.push_back(mk_row(OP_TAKE, 31, 0, 0, 1, OUT_TAKEN, 'h8001, 1, 1));
        dir_rows.push_back(mk_row(OP_TAKE, 31, 0, 0, 1, OUT_TAKEN, 'h7FFE, 0, 0));

        // Reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].op_in, dir_rows[i].typed, dir_rows[i].res);
            idle_gap(pick_gap());
        end
        idle_gap(1);

        // Random phases, one limit each; lowering the limit leaves deep queues behind
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(CAP_W'(phase_cap[p]));
            hot_base = CLASS_W'($urandom);
            no_gaps = (p % 3 == 1);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                it.op  = ($urandom_range(0, 99) < phase_add_pct[p]) ? OP_ADD : OP_TAKE;
                it.cls = ($urandom_range(0, 99) < 75) ?
                         hot_base + CLASS_W'($urandom_range(0, 3)) : CLASS_W'($urandom);
                it.tag = TAG_W'($urandom);
                it.urg = 1'($urandom_range(0, 1));
                send_beat(it, 1'b0, '0);
                idle_gap(no_gaps ? 0 : pick_gap());
            end
            idle_gap(1);
        end

        // Drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
